/* rtl/core/lpg_pkg.sv */
`default_nettype none

package lpg_pkg;

	localparam int COORD_BITS = 11;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
		coord_t step_index;
	} in_word_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		logic   inside_span;
	} out_word_t;

endpackage

`default_nettype wire

/* rtl/core/line_pixel_generator_top.sv */
// channel   direction  handshake                 payload
// command   in         start high, busy low      cmd    (lpg_pkg::in_word_t)
// result    out        done high for one cycle   result (lpg_pkg::out_word_t)
//
// one word accepted every cycle, busy is never raised
// a word travels from the accepting edge to done through the five set-up
// stages, one restoring divider stage per quotient bit and the output
// register
// asynchronous reset clears every stage valid bit and done
// the receiver cannot stall, so the pipeline never holds
`default_nettype none

module line_pixel_generator_top (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  lpg_pkg::in_word_t cmd,
	output logic             done,
	output lpg_pkg::out_word_t result
);

	import lpg_pkg::*;

	localparam int C = COORD_BITS;
	localparam int LATENCY = C + 6;

	typedef logic signed [C:0] delta_t;

	typedef struct packed {
		logic   x_major;
		logic   in_span;
		logic   neg;
		coord_t maj;
		coord_t s_min;
	} pay_t;

	typedef struct packed {
		pay_t   pay;
		coord_t span;
		coord_t rem;
		coord_t lo;
		coord_t quo;
	} div_t;

	// stage 1: input register
	logic     v_s1;
	in_word_t w_s1;

	// stage 2: deltas
	logic   v_s2;
	delta_t dx_s2, dy_s2;
	coord_t sx_s2, sy_s2, ex_s2, ey_s2, step_s2;

	// stage 3: axis choice
	logic   v_s3;
	logic   x_major_s3, dmaj_neg_s3, dmin_neg_s3;
	coord_t span_s3, dmin_abs_s3, s_maj_s3, e_maj_s3, s_min_s3, step_s3;

	// stage 4: major coordinate and multiplier operand
	logic   v_s4;
	pay_t   pay_s4;
	coord_t span_s4, dmin_abs_s4, u_s4;

	// stage 5: product
	logic            v_s5;
	pay_t            pay_s5;
	coord_t          span_s5;
	logic [2*C-1:0]  prod_s5;

	// divider stages
	logic [C-1:0] v_div;
	div_t         div_s [C];

	logic      done_q;
	out_word_t result_q;

	delta_t adx_c, ady_c;
	coord_t adx3, ady3;
	logic   x_major_c;
	coord_t low_c;
	coord_t qadj_c, off_c, minor_c;
	div_t   last_c;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		w_s1 <= cmd;
	end

	always_ff @(posedge clk) begin
		dx_s2   <= delta_t'({1'b0, w_s1.end_x}) - delta_t'({1'b0, w_s1.start_x});
		dy_s2   <= delta_t'({1'b0, w_s1.end_y}) - delta_t'({1'b0, w_s1.start_y});
		sx_s2   <= w_s1.start_x;
		sy_s2   <= w_s1.start_y;
		ex_s2   <= w_s1.end_x;
		ey_s2   <= w_s1.end_y;
		step_s2 <= w_s1.step_index;
	end

	always_comb begin
		adx_c     = dx_s2[C] ? -dx_s2 : dx_s2;
		ady_c     = dy_s2[C] ? -dy_s2 : dy_s2;
		adx3      = adx_c[C-1:0];
		ady3      = ady_c[C-1:0];
		x_major_c = adx3 > ady3;
	end

	always_ff @(posedge clk) begin
		x_major_s3  <= x_major_c;
		span_s3     <= x_major_c ? adx3 : ady3;
		dmaj_neg_s3 <= x_major_c ? dx_s2[C] : dy_s2[C];
		dmin_neg_s3 <= x_major_c ? dy_s2[C] : dx_s2[C];
		dmin_abs_s3 <= x_major_c ? ady3 : adx3;
		s_maj_s3    <= x_major_c ? sx_s2 : sy_s2;
		e_maj_s3    <= x_major_c ? ex_s2 : ey_s2;
		s_min_s3    <= x_major_c ? sy_s2 : sx_s2;
		step_s3     <= step_s2;
	end

	assign low_c = dmaj_neg_s3 ? e_maj_s3 : s_maj_s3;

	always_ff @(posedge clk) begin
		pay_s4.x_major <= x_major_s3;
		pay_s4.in_span <= step_s3 < span_s3;
		pay_s4.neg     <= dmin_neg_s3;
		pay_s4.maj     <= low_c + step_s3;
		pay_s4.s_min   <= s_min_s3;
		span_s4        <= span_s3;
		dmin_abs_s4    <= dmin_abs_s3;
		u_s4           <= dmaj_neg_s3 ? span_s3 - step_s3 : step_s3;
	end

	always_ff @(posedge clk) begin
		pay_s5  <= pay_s4;
		span_s5 <= span_s4;
		prod_s5 <= (2*C)'(dmin_abs_s4) * (2*C)'(u_s4);
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < C; k++) begin : g_div
		div_t        src;
		logic [C:0]  trial;
		logic        ge;

		if (k == 0) begin : g_first
			logic v_src;
			assign v_src        = v_s5;
			assign src.pay      = pay_s5;
			assign src.span     = span_s5;
			assign src.rem      = prod_s5[2*C-1:C];
			assign src.lo       = prod_s5[C-1:0];
			assign src.quo      = '0;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_div[k] <= 1'b0;
				end else begin
					v_div[k] <= v_src;
				end
			end
		end else begin : g_next
			assign src = div_s[k-1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_div[k] <= 1'b0;
				end else begin
					v_div[k] <= v_div[k-1];
				end
			end
		end

		assign trial = {src.rem, src.lo[C-1]};
		assign ge    = trial >= {1'b0, src.span};

		always_ff @(posedge clk) begin
			div_s[k].pay  <= src.pay;
			div_s[k].span <= src.span;
			div_s[k].rem  <= ge ? C'(trial - {1'b0, src.span}) : trial[C-1:0];
			div_s[k].lo   <= {src.lo[C-2:0], 1'b0};
			div_s[k].quo  <= {src.quo[C-2:0], ge};
		end
	end

	// floor for a negative numerator rounds the magnitude up
	always_comb begin
		last_c  = div_s[C-1];
		qadj_c  = last_c.quo + C'(last_c.rem != '0);
		off_c   = last_c.pay.neg ? -qadj_c : last_c.quo;
		minor_c = last_c.pay.s_min + off_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_div[C-1];
		end
	end

	always_ff @(posedge clk) begin
		if (last_c.pay.in_span) begin
			result_q.pixel_x <= last_c.pay.x_major ? last_c.pay.maj : minor_c;
			result_q.pixel_y <= last_c.pay.x_major ? minor_c : last_c.pay.maj;
		end else begin
			result_q.pixel_x <= '0;
			result_q.pixel_y <= '0;
		end
		result_q.inside_span <= last_c.pay.in_span;
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("word lost in pipeline");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("word invented by pipeline");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.inside_span) |-> (result.pixel_x == '0 && result.pixel_y == '0))
		else $error("pixel not cleared outside span");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_div[C-1] && div_s[C-1].pay.in_span) |-> (div_s[C-1].rem < div_s[C-1].span))
		else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
